// ===== sv/fpip_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// fpip_pkg
// Shared types and constants for the binary64 integer power block.
// ============================================================================
package fpip_pkg;

    // binary64 constants
    localparam logic [63:0] ONE_BITS      = 64'h3FF0_0000_0000_0000;
    localparam logic [63:0] DEFAULT_NAN   = 64'hFFF8_0000_0000_0000;
    localparam logic [10:0] EXP_MAX       = 11'h7FF;
    // magnitude bits of 1e-7; |x| below this is near zero
    localparam logic [62:0] NEAR_ZERO_MAG = 63'h3E7A_D7F2_9ABC_AF48;

    // operation of the shared float unit
    typedef enum logic
    {
        FPU_MUL,
        FPU_RECIP
    } fpu_op_t;

    // controller to datapath commands
    typedef struct packed
    {
        logic    load_in;
        logic    idx_dec;
        logic    acc_load;
        logic    fpu_start;
        fpu_op_t fpu_op;
        logic    use_base;
        logic    out_load;
        logic    out_invalid;
    } ctrl_cmd_t;

    // datapath to controller status
    typedef struct packed
    {
        logic invalid_case;
        logic mag_zero;
        logic negative;
        logic mag_bit;
        logic idx_zero;
        logic fpu_done;
    } dp_status_t;

endpackage

// ===== sv/float_power_integer_exponent_top.sv =====
`timescale 1ns / 1ps
// ============================================================================
// float_power_integer_exponent_top
// binary64 base raised to a signed integer power by square-and-multiply.
// ============================================================================
//  channel  dir  tdata                                   tuser
//  s_axis   in   base[63:0], exponent[EXPONENT_BITS-1:0]  -
//  m_axis   out  power_bits[63:0]                         invalid
//
// One request at a time. A square or multiply runs on the shared float unit:
// it accumulates three partial products, normalizes, shifts into the subnormal
// range where needed and rounds. The reciprocal takes longer, more for a
// subnormal operand. An exponent costs up to one square and one multiply per
// exponent bit, plus the reciprocal.
// Reset is asynchronous, active low, and clears all control state.
// A waiting result sits in the output register while the next request is taken.
// ============================================================================
module float_power_integer_exponent_top
#(
    parameter int EXPONENT_BITS = 32
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // base, exponent from bit 0 up
    input  logic [((64+EXPONENT_BITS+7)/8)*8-1:0] s_tdata,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // power_bits
    output logic [63:0]                           m_tdata,
    // invalid
    output logic                                  m_tuser
);

    fpip_pkg::ctrl_cmd_t  cmd;
    fpip_pkg::dp_status_t status;

    fpip_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .status    (status),
        .cmd       (cmd)
    );

    fpip_datapath #(.EXPONENT_BITS(EXPONENT_BITS)) u_datapath
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .base       (s_tdata[63:0]),
        .exponent   (s_tdata[64 +: EXPONENT_BITS]),
        .status     (status),
        .power_bits (m_tdata),
        .invalid    (m_tuser)
    );

endmodule

// ===== sv/fpip_fpu.sv =====
`timescale 1ns / 1ps
// ============================================================================
// fpip_fpu
// Multi-cycle binary64 unit: a * b or 1.0 / a, round to nearest even.
// ============================================================================
module fpip_fpu
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  fpip_pkg::fpu_op_t    op,
    input  logic [63:0]          a,
    input  logic [63:0]          b,
    output logic                 done,
    output logic [63:0]          result
);

    typedef enum logic [2:0]
    {
        F_IDLE,
        F_MUL,
        F_DIVN,
        F_DIV,
        F_NORM,
        F_DENORM,
        F_ROUND,
        F_DONE
    } fstate_t;

    fstate_t             fstate_reg, fstate_next;
    logic                sign_reg, sign_next;
    logic signed [12:0]  exp_reg, exp_next;
    logic [52:0]         ma_reg, ma_next;
    logic [53:0]         mb_reg, mb_next;
    logic [53:0]         rem_reg, rem_next;
    logic [55:0]         quo_reg, quo_next;
    logic [105:0]        prod_reg, prod_next;
    logic [5:0]          cnt_reg, cnt_next;
    logic [63:0]         res_reg, res_next;

    // operand classification
    logic [10:0] a_exp, b_exp;
    logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
    logic [70:0] pp;
    logic [105:0] pp_shift;
    logic        ge;
    logic [53:0] diff;
    logic        rnd_inc;
    logic [10:0] efield;

    assign a_exp  = a[62:52];
    assign b_exp  = b[62:52];
    assign a_nan  = (a_exp == fpip_pkg::EXP_MAX) && (a[51:0] != 52'd0);
    assign b_nan  = (b_exp == fpip_pkg::EXP_MAX) && (b[51:0] != 52'd0);
    assign a_inf  = (a_exp == fpip_pkg::EXP_MAX) && (a[51:0] == 52'd0);
    assign b_inf  = (b_exp == fpip_pkg::EXP_MAX) && (b[51:0] == 52'd0);
    assign a_zero = (a[62:0] == 63'd0);
    assign b_zero = (b[62:0] == 63'd0);

    // 53 x 18 partial product, one multiplier digit per cycle
    assign pp = {18'd0, ma_reg} * {53'd0, mb_reg[17:0]};

    always_comb
    begin
        case (cnt_reg[1:0])
            2'd0:    pp_shift = {35'd0, pp};
            2'd1:    pp_shift = {17'd0, pp, 18'd0};
            default: pp_shift = {pp[69:0], 36'd0};
        endcase
    end

    // restoring division step
    assign ge   = (rem_reg >= {1'b0, ma_reg});
    assign diff = ge ? (rem_reg - {1'b0, ma_reg}) : rem_reg;

    // rounding
    assign rnd_inc = prod_reg[52] & ((|prod_reg[51:0]) | prod_reg[53]);
    assign efield  = prod_reg[105] ? exp_reg[10:0] : 11'd0;

    always_comb
    begin
        fstate_next = fstate_reg;
        sign_next   = sign_reg;
        exp_next    = exp_reg;
        ma_next     = ma_reg;
        mb_next     = mb_reg;
        rem_next    = rem_reg;
        quo_next    = quo_reg;
        prod_next   = prod_reg;
        cnt_next    = cnt_reg;
        res_next    = res_reg;

        case (fstate_reg)
            F_IDLE:
            begin
                if (start)
                begin
                    fstate_next = F_DONE;
                    cnt_next    = 6'd0;
                    if (op == fpip_pkg::FPU_MUL)
                    begin
                        sign_next = a[63] ^ b[63];
                        if (a_nan)
                            res_next = a | 64'h0008_0000_0000_0000;
                        else if (b_nan)
                            res_next = b | 64'h0008_0000_0000_0000;
                        else if ((a_inf && b_zero) || (a_zero && b_inf))
                            res_next = fpip_pkg::DEFAULT_NAN;
                        else if (a_inf || b_inf)
                            res_next = {a[63] ^ b[63], fpip_pkg::EXP_MAX, 52'd0};
                        else if (a_zero || b_zero)
                            res_next = {a[63] ^ b[63], 63'd0};
                        else
                        begin
                            ma_next   = {a_exp != 11'd0, a[51:0]};
                            mb_next   = {1'b0, b_exp != 11'd0, b[51:0]};
                            exp_next  = 13'(a_exp == 11'd0 ? 11'd1 : a_exp)
                                      + 13'(b_exp == 11'd0 ? 11'd1 : b_exp)
                                      - 13'sd1022;
                            prod_next = 106'd0;
                            fstate_next = F_MUL;
                        end
                    end
                    else
                    begin
                        sign_next = a[63];
                        if (a_zero)
                            res_next = {a[63], fpip_pkg::EXP_MAX, 52'd0};
                        else if (a_nan)
                            res_next = a | 64'h0008_0000_0000_0000;
                        else if (a_inf)
                            res_next = {a[63], 63'd0};
                        else
                        begin
                            ma_next  = {a_exp != 11'd0, a[51:0]};
                            exp_next = 13'(a_exp == 11'd0 ? 11'd1 : a_exp);
                            fstate_next = F_DIVN;
                        end
                    end
                end
            end

            // accumulate three partial products
            F_MUL:
            begin
                prod_next = prod_reg + pp_shift;
                mb_next   = {18'd0, mb_reg[53:18]};
                cnt_next  = cnt_reg + 6'd1;
                if (cnt_reg == 6'd2)
                    fstate_next = F_NORM;
            end

            // normalize the divisor, then set up quotient exponent
            F_DIVN:
            begin
                if (ma_reg[52])
                begin
                    rem_next    = 54'd1 << 52;
                    exp_next    = 13'sd2046 - exp_reg;
                    fstate_next = F_DIV;
                end
                else
                begin
                    ma_next  = {ma_reg[51:0], 1'b0};
                    exp_next = exp_reg - 13'sd1;
                end
            end

            // one quotient bit per cycle, 56 bits
            F_DIV:
            begin
                rem_next = {diff[52:0], 1'b0};
                quo_next = {quo_reg[54:0], ge};
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd55)
                begin
                    prod_next   = {quo_reg[54:0], ge, 49'd0, diff != 54'd0};
                    fstate_next = F_NORM;
                end
            end

            // left normalize one bit per cycle
            F_NORM:
            begin
                if (!prod_reg[105] && (exp_reg > 13'sd1))
                begin
                    prod_next = {prod_reg[104:0], 1'b0};
                    exp_next  = exp_reg - 13'sd1;
                end
                else if (exp_reg < 13'sd1)
                    fstate_next = F_DENORM;
                else
                    fstate_next = F_ROUND;
            end

            // right shift into the subnormal range, jamming sticky
            F_DENORM:
            begin
                if (exp_reg < -13'sd110)
                begin
                    prod_next = {105'd0, 1'b1};
                    exp_next  = 13'sd1;
                end
                else if (exp_reg < 13'sd1)
                begin
                    prod_next = {1'b0, prod_reg[105:2], prod_reg[1] | prod_reg[0]};
                    exp_next  = exp_reg + 13'sd1;
                end
                else
                    fstate_next = F_ROUND;
            end

            F_ROUND:
            begin
                if (exp_reg >= 13'sd2047)
                    res_next = {sign_reg, fpip_pkg::EXP_MAX, 52'd0};
                else
                    res_next = {sign_reg,
                                {efield, prod_reg[104:53]} + {62'd0, rnd_inc}};
                fstate_next = F_DONE;
            end

            F_DONE:
            begin
                fstate_next = F_IDLE;
            end

            default:
            begin
                fstate_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fstate_reg <= F_IDLE;
        else
            fstate_reg <= fstate_next;
    end

    always_ff @(posedge clk)
    begin
        sign_reg <= sign_next;
        exp_reg  <= exp_next;
        ma_reg   <= ma_next;
        mb_reg   <= mb_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        prod_reg <= prod_next;
        cnt_reg  <= cnt_next;
        res_reg  <= res_next;
    end

    assign done   = (fstate_reg == F_DONE);
    assign result = res_reg;

endmodule

// ===== sv/fpip_datapath.sv =====
`timescale 1ns / 1ps
// ============================================================================
// fpip_datapath
// Operand, exponent scan, accumulator and output registers around the FPU.
// ============================================================================
module fpip_datapath
#(
    parameter int EXPONENT_BITS = 32
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  fpip_pkg::ctrl_cmd_t        cmd,
    input  logic [63:0]                base,
    input  logic [EXPONENT_BITS-1:0]   exponent,
    output fpip_pkg::dp_status_t       status,
    output logic [63:0]                power_bits,
    output logic                       invalid
);

    localparam int IW = (EXPONENT_BITS > 1) ? $clog2(EXPONENT_BITS) : 1;

    logic [63:0]              base_reg;
    logic                     neg_reg;
    logic                     nz_reg;
    logic [EXPONENT_BITS-1:0] mag_reg;
    logic [IW-1:0]            idx_reg;
    logic [63:0]              acc_reg;
    logic [63:0]              out_bits_reg;
    logic                     out_inv_reg;
    logic [63:0]              fpu_result;
    logic                     fpu_done;
    logic [EXPONENT_BITS-1:0] mag_in;

    // magnitude of the two's complement exponent
    assign mag_in = exponent[EXPONENT_BITS-1] ? (~exponent + 1'b1) : exponent;

    fpip_fpu u_fpu
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cmd.fpu_start),
        .op     (cmd.fpu_op),
        .a      (acc_reg),
        .b      (cmd.use_base ? base_reg : acc_reg),
        .done   (fpu_done),
        .result (fpu_result)
    );

    // operand and accumulator registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            base_reg <= base;
            neg_reg  <= exponent[EXPONENT_BITS-1];
            nz_reg   <= (base[62:0] < fpip_pkg::NEAR_ZERO_MAG);
            mag_reg  <= mag_in;
            idx_reg  <= IW'(EXPONENT_BITS - 1);
            acc_reg  <= fpip_pkg::ONE_BITS;
        end
        else
        begin
            if (cmd.idx_dec)
                idx_reg <= idx_reg - 1'b1;
            if (cmd.acc_load)
                acc_reg <= fpu_result;
        end
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_bits_reg <= cmd.out_invalid ? 64'd0 : acc_reg;
            out_inv_reg  <= cmd.out_invalid;
        end
    end

    always_comb
    begin
        status.invalid_case = neg_reg & nz_reg;
        status.mag_zero     = (mag_reg == '0);
        status.negative     = neg_reg;
        status.mag_bit      = mag_reg[idx_reg];
        status.idx_zero     = (idx_reg == '0);
        status.fpu_done     = fpu_done;
    end

    assign power_bits = out_bits_reg;
    assign invalid    = out_inv_reg;

endmodule

// ===== sv/fpip_ctrl.sv =====
`timescale 1ns / 1ps
// ============================================================================
// fpip_ctrl
// Sequencer for square-and-multiply, final reciprocal and the result request.
// ============================================================================
module fpip_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    input  fpip_pkg::dp_status_t  status,
    output fpip_pkg::ctrl_cmd_t   cmd
);

    typedef enum logic [3:0]
    {
        S_IDLE,
        S_CHECK,
        S_SCAN,
        S_SQ,
        S_SQ_WAIT,
        S_MX,
        S_MX_WAIT,
        S_NEXT,
        S_RCP,
        S_RCP_WAIT,
        S_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   inv_reg, inv_next;

    // next state and commands
    always_comb
    begin
        state_next     = state_reg;
        inv_next       = inv_reg;
        out_valid_next = out_valid_reg & ~out_ready;
        cmd            = '0;
        cmd.fpu_op     = fpip_pkg::FPU_MUL;
        in_ready       = (state_reg == S_IDLE);

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_CHECK;
                end
            end

            S_CHECK:
            begin
                inv_next = status.invalid_case;
                if (status.invalid_case || status.mag_zero)
                    state_next = S_FINISH;
                else
                    state_next = S_SCAN;
            end

            // skip leading zero bits of the magnitude
            S_SCAN:
            begin
                if (status.mag_bit)
                    state_next = S_SQ;
                else
                    cmd.idx_dec = 1'b1;
            end

            S_SQ:
            begin
                cmd.fpu_start = 1'b1;
                state_next    = S_SQ_WAIT;
            end

            S_SQ_WAIT:
            begin
                if (status.fpu_done)
                begin
                    cmd.acc_load = 1'b1;
                    state_next   = status.mag_bit ? S_MX : S_NEXT;
                end
            end

            S_MX:
            begin
                cmd.fpu_start = 1'b1;
                cmd.use_base  = 1'b1;
                state_next    = S_MX_WAIT;
            end

            S_MX_WAIT:
            begin
                if (status.fpu_done)
                begin
                    cmd.acc_load = 1'b1;
                    state_next   = S_NEXT;
                end
            end

            S_NEXT:
            begin
                if (status.idx_zero)
                    state_next = status.negative ? S_RCP : S_FINISH;
                else
                begin
                    cmd.idx_dec = 1'b1;
                    state_next  = S_SQ;
                end
            end

            S_RCP:
            begin
                cmd.fpu_start = 1'b1;
                cmd.fpu_op    = fpip_pkg::FPU_RECIP;
                state_next    = S_RCP_WAIT;
            end

            S_RCP_WAIT:
            begin
                cmd.fpu_op = fpip_pkg::FPU_RECIP;
                if (status.fpu_done)
                begin
                    cmd.acc_load = 1'b1;
                    state_next   = S_FINISH;
                end
            end

            // hand off once the output register is free
            S_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load    = 1'b1;
                    cmd.out_invalid = inv_reg;
                    out_valid_next  = 1'b1;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            inv_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            inv_reg       <= inv_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// ===== tb/float_power_integer_exponent_top_tb.sv =====
`timescale 1ns / 1ps
// ============================================================================
// float_power_integer_exponent_top_tb
// Self-checking bench for the binary64 integer power block.
// Drives base/exponent requests with random gaps and output stalls. Each
// accepted request is evaluated by a square-and-multiply model on host
// doubles. Each result is compared in order against the expected power and
// invalid flag.
// ============================================================================
module float_power_integer_exponent_top_tb;

    localparam int  EXP_W      = 32;
    localparam int  DATA_W     = ((64 + EXP_W + 7) / 8) * 8;
    localparam int  WDOG_LIMIT = 40000;
    localparam real NEAR_ZERO  = 0.0000001;

    // expected results and the power model
    class power_scoreboard;
        logic [63:0] exp_power[$];
        logic        exp_invalid[$];
        int          errors = 0;

        function void report(string msg);
            $display("MISMATCH @%0t: %s", $realtime, msg);
            errors++;
        endfunction

        // square-and-multiply from the top set bit of the magnitude
        function real raise_unsigned(real x, logic [EXP_W-1:0] mag);
            real acc;
            int  top;
            acc = 1.0;
            top = -1;
            for (int b = EXP_W - 1; b >= 0; b--)
                if (mag[b] && top < 0) top = b;
            for (int b = top; b >= 0; b--)
            begin
                acc = acc * acc;
                if (mag[b]) acc = acc * x;
            end
            return acc;
        endfunction

        // note an accepted request
        function void note(logic [63:0] base, logic [EXP_W-1:0] expo);
            logic              neg;
            logic [EXP_W-1:0]  mag;
            real               x;
            real               r;
            logic [63:0]       rb;
            neg = expo[EXP_W-1];
            mag = neg ? -expo : expo;
            x   = $bitstoreal(base);
            if (neg && x > -NEAR_ZERO && x < NEAR_ZERO)
            begin
                exp_power.push_back(64'd0);
                exp_invalid.push_back(1'b1);
                return;
            end
            r  = raise_unsigned(x, mag);
            rb = $realtobits(r);
            if (neg)
            begin
                // reciprocal of a signed zero is the same-sign infinity
                if (rb[62:0] == 63'd0)
                    rb = {rb[63], 63'h7FF0_0000_0000_0000};
                else
                    rb = $realtobits(1.0 / r);
            end
            exp_power.push_back(rb);
            exp_invalid.push_back(1'b0);
        endfunction

        // check an accepted result
        function void check(logic [63:0] power, logic invalid);
            logic [63:0] ep;
            logic        ei;
            if (exp_power.size() == 0)
            begin
                report($sformatf("unexpected result %h", power));
                return;
            end
            ep = exp_power.pop_front();
            ei = exp_invalid.pop_front();
            if (power !== ep)
                report($sformatf("power_bits %h, expected %h", power, ep));
            if (invalid !== ei)
                report($sformatf("invalid %b, expected %b", invalid, ei));
        endfunction

        function int pending();
            return exp_power.size();
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              s_tvalid;
    logic              s_tready;
    logic [DATA_W-1:0] s_tdata;
    logic              m_tvalid;
    logic              m_tready;
    logic [63:0]       m_tdata;
    logic              m_tuser;

    power_scoreboard sb;
    bit              no_idle;
    int              quiet_cycles;

    float_power_integer_exponent_top #(.EXPONENT_BITS(EXP_W)) dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // output stall pattern
    always @(posedge clk)
    begin
        m_tready <= no_idle || ($urandom_range(99) >= 28);
    end

    // monitors and watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                sb.note(s_tdata[63:0], s_tdata[64 +: EXP_W]);
            if (m_tvalid && m_tready)
                sb.check(m_tdata, m_tuser);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WDOG_LIMIT)
            begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // present one request and hold it until accepted
    task send_request(logic [63:0] base, logic [EXP_W-1:0] expo);
        s_tvalid <= 1'b1;
        s_tdata  <= {{(DATA_W - 64 - EXP_W){1'b0}}, expo, base};
        do @(posedge clk); while (!s_tready);
    endtask

    // random sender gap
    task sender_gap();
        if (!no_idle && $urandom_range(99) < 28)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    function logic [63:0] pick_base();
        int sel;
        sel = $urandom_range(99);
        if (sel < 35)       // near 1.0 so long powers stay finite
            return {1'($urandom), 11'h3FF - 11'($urandom_range(1)),
                    32'($urandom), 20'($urandom)} & 64'hFFF0_00FF_FFFF_FFFF
                   | (($urandom_range(1)) ? 64'h0 : 64'h000F_FF00_0000_0000);
        else if (sel < 55)  // moderate magnitudes
            return {1'($urandom), 11'($urandom_range(900, 1150)),
                    20'($urandom), 32'($urandom)};
        else if (sel < 62)  // subnormal and tiny
            return {1'($urandom), 11'($urandom_range(1)), 20'($urandom), 32'($urandom)};
        else if (sel < 70)  // around the near-zero bound
            return {1'($urandom), 63'h3E7A_D7F2_9ABC_AF48 + 63'($signed($urandom_range(8)) - 4)};
        else if (sel < 76)  // zero, infinity, NaN
            case ($urandom_range(2))
                0:       return {1'($urandom), 63'd0};
                1:       return {1'($urandom), 63'h7FF0_0000_0000_0000};
                default: return {1'($urandom), 11'h7FF, 20'($urandom) | 20'h1, 32'($urandom)};
            endcase
        else
            return {$urandom, $urandom};
    endfunction

    function logic [EXP_W-1:0] pick_exponent();
        int sel;
        sel = $urandom_range(99);
        if (sel < 70)
            return EXP_W'($signed($urandom_range(80)) - 40);
        else if (sel < 85)
            return EXP_W'($signed($urandom_range(4000)) - 2000);
        else
            return EXP_W'($urandom);
    endfunction

    initial
    begin
        sb           = new();
        no_idle      = 1'b0;
        quiet_cycles = 0;
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        m_tready     = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: zero exponent, near-zero bound, extremes, zero reciprocal
        send_request(64'h0000_0000_0000_0000, 32'd0);
        send_request(64'h7FF0_0000_0000_0000, 32'd0);
        send_request(64'hFFF8_0000_0000_0001, 32'd0);
        send_request(64'h3E7A_D7F2_9ABC_AF48, -32'sd1);
        send_request(64'h3E7A_D7F2_9ABC_AF47, -32'sd1);
        send_request(64'hBE7A_D7F2_9ABC_AF48, -32'sd1);
        send_request(64'hBE7A_D7F2_9ABC_AF47, -32'sd3);
        send_request(64'h8000_0000_0000_0000, -32'sd2);
        send_request(64'h0000_0000_0000_0001, 32'd2);
        send_request(64'h3FF0_0000_0000_0000, 32'h8000_0000);
        send_request(64'h4000_0000_0000_0000, 32'h8000_0000);
        send_request(64'hBFF0_0000_0000_0001, 32'h7FFF_FFFF);
        send_request(64'h3FE0_0000_0000_0000, -32'sd2000);
        send_request(64'hBFE0_0000_0000_0000, -32'sd1075);
        send_request(64'h4000_0000_0000_0000, 32'd1024);
        send_request(64'hC000_0000_0000_0000, 32'd1023);
        send_request(64'h7FF0_0000_0000_0000, -32'sd1);
        send_request(64'hFFF0_0000_0000_0000, 32'd3);
        send_request(64'h7FF8_0000_0000_0000, -32'sd5);
        send_request(64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
        send_request(64'h4009_21FB_5444_2D18, 32'd7);
        send_request(64'h000F_FFFF_FFFF_FFFF, -32'sd1);
        s_tvalid <= 1'b0;

        // hold off until the pipe drains
        while (sb.pending() != 0) @(posedge clk);

        // random traffic, with a stretch of back-to-back requests
        for (int n = 0; n < 2000; n++)
        begin
            no_idle = (n >= 900 && n < 1200);
            sender_gap();
            send_request(pick_base(), pick_exponent());
        end
        s_tvalid <= 1'b0;
        no_idle = 1'b0;

        while (sb.pending() != 0) @(posedge clk);
        repeat (600) @(posedge clk);

        if (sb.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/fpip_pkg.sv
sv/fpip_fpu.sv
sv/fpip_datapath.sv
sv/fpip_ctrl.sv
sv/float_power_integer_exponent_top.sv
tb/float_power_integer_exponent_top_tb.sv
